// ===== sv/swbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swbc_pkg;

    localparam int AGE_BITS = 32;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_LOOKUP = 4'b0100,
        ST_SELECT = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ===== sv/set_assoc_writeback_cache_core.sv =====
// Set-associative write-back, write-allocate cache core with a line-wide
// backing memory behind it. Each input transfer (s_opcode, s_address,
// s_write_data) is one byte read or write; each produces exactly one
// output transfer (m_read_byte, m_line_data, m_hit, m_was_dirty).
// An item goes through these steps from input transfer to m_valid: the
// synchronous read of the set row and of the addressed backing line, then
// the age update and tag compare, then picking the way, writing the set row
// back and writing back a dirty victim line. The next item is taken in the
// cycle after the result is registered, so the core takes no new item
// before it is through with the last one; hits and misses cost the same
// because the fill line is read from backing memory alongside the set row.
// After reset the core sweeps the backing memory to zero, one line per
// cycle, all 2**(ADDR_BITS - log2(LINE_BYTES)) lines (8192 by default),
// with s_ready low. Set rows start as zero through per-set valid flags.
// A result waits in the output register while m_ready is low; a new item
// may be taken meanwhile, but it holds in its last step until the output
// register frees, and no state is written before then.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_writeback_cache_core
    import swbc_pkg::*;
#(
    parameter int NUM_SETS   = 16,
    parameter int NUM_WAYS   = 4,
    parameter int LINE_BYTES = 8,
    parameter int ADDR_BITS  = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_opcode,
    input  wire logic [ADDR_BITS-1:0] s_address,
    input  wire logic [7:0]           s_write_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_read_byte,
    output logic [63:0]               m_line_data,
    output logic                      m_hit,
    output logic                      m_was_dirty
);

    localparam int OFF_BITS  = $clog2(LINE_BYTES);
    localparam int SET_BITS  = $clog2(NUM_SETS);
    localparam int WAY_BITS  = $clog2(NUM_WAYS);
    localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - SET_BITS;
    localparam int LINE_BITS = LINE_BYTES * 8;
    localparam int MIDX_BITS = ADDR_BITS - OFF_BITS;
    localparam int MEM_LINES = 1 << MIDX_BITS;
    localparam int OUT_BITS  = (LINE_BITS < 64) ? LINE_BITS : 64;

    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic                 dirty;
        logic [AGE_BITS-1:0]  age;
        logic [LINE_BITS-1:0] line;
    } way_t;

    typedef way_t [NUM_WAYS-1:0] row_t;

    row_t                 cache_mem [NUM_SETS];
    logic [LINE_BITS-1:0] back_mem  [MEM_LINES];

    state_t               state_reg, state_next;
    logic [MIDX_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [NUM_SETS-1:0]  row_valid_reg, row_valid_next;
    logic                 m_valid_reg, m_valid_next;

    logic                 op_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [7:0]           wdata_reg;
    row_t                 cache_rd_reg;
    logic [LINE_BITS-1:0] mem_rd_reg;
    row_t                 row_reg, row_next;
    logic                 hit_reg, hit_next;
    logic [WAY_BITS-1:0]  hit_way_reg, hit_way_next;

    logic [7:0]           m_read_byte_reg;
    logic [63:0]          m_line_data_reg;
    logic                 m_hit_reg;
    logic                 m_was_dirty_reg;

    logic                 accept;
    logic                 out_free;
    logic                 commit;
    logic [SET_BITS-1:0]  set_sel;
    logic [TAG_BITS-1:0]  tag_sel;
    logic [OFF_BITS-1:0]  off_sel;
    row_t                 row_in;

    logic [WAY_BITS-1:0]  victim;
    logic [AGE_BITS-1:0]  best_age;
    logic [WAY_BITS-1:0]  ch_idx;
    way_t                 ch_way;
    logic [LINE_BITS-1:0] sel_line;
    logic [LINE_BITS-1:0] upd_line;
    logic [7:0]           sel_byte;
    row_t                 new_row;

    logic                 mem_we;
    logic [MIDX_BITS-1:0] mem_waddr;
    logic [LINE_BITS-1:0] mem_wdata;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_SELECT) && out_free;

    assign set_sel = addr_reg[OFF_BITS +: SET_BITS];
    assign tag_sel = addr_reg[ADDR_BITS-1 -: TAG_BITS];
    assign off_sel = addr_reg[OFF_BITS-1:0];

    // age update and tag compare
    always_comb begin
        row_in       = row_valid_reg[set_sel] ? cache_rd_reg : '0;
        row_next     = row_in;
        hit_next     = 1'b0;
        hit_way_next = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (row_in[w].age != AGE_MAX) begin
                row_next[w].age = row_in[w].age + AGE_BITS'(1);
            end
            if (row_in[w].tag == tag_sel) begin
                hit_next     = 1'b1;
                hit_way_next = WAY_BITS'(w);
            end
        end
    end

    // way choice and row update
    always_comb begin
        victim   = '0;
        best_age = row_reg[0].age;
        for (int w = 1; w < NUM_WAYS; w++) begin
            if (row_reg[w].age > best_age) begin
                best_age = row_reg[w].age;
                victim   = WAY_BITS'(w);
            end
        end
        ch_idx   = hit_reg ? hit_way_reg : victim;
        ch_way   = row_reg[ch_idx];
        sel_line = hit_reg ? ch_way.line : mem_rd_reg;
        sel_byte = sel_line[{off_sel, 3'b000} +: 8];
        upd_line = sel_line;
        if (op_reg == OP_WRITE) begin
            upd_line[{off_sel, 3'b000} +: 8] = wdata_reg;
        end
        new_row                = row_reg;
        new_row[ch_idx].age    = '0;
        new_row[ch_idx].tag    = tag_sel;
        new_row[ch_idx].dirty  = (hit_reg && ch_way.dirty) || (op_reg == OP_WRITE);
        new_row[ch_idx].line   = upd_line;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (commit && !hit_reg && ch_way.dirty) begin
            mem_we    = 1'b1;
            mem_waddr = {ch_way.tag, set_sel};
            mem_wdata = ch_way.line;
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        row_valid_next = row_valid_reg;
        m_valid_next   = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + MIDX_BITS'(1);
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_SELECT;
            end
            ST_SELECT: begin
                if (out_free) begin
                    state_next              = ST_IDLE;
                    row_valid_next[set_sel] = 1'b1;
                    m_valid_next            = 1'b1;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_opcode;
            addr_reg  <= s_address;
            wdata_reg <= s_write_data;
        end
        if (state_reg == ST_LOOKUP) begin
            row_reg     <= row_next;
            hit_reg     <= hit_next;
            hit_way_reg <= hit_way_next;
        end
        if (commit) begin
            m_read_byte_reg <= sel_byte;
            m_line_data_reg <= 64'(sel_line[OUT_BITS-1:0]);
            m_hit_reg       <= hit_reg;
            m_was_dirty_reg <= ch_way.dirty;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            cache_mem[set_sel] <= new_row;
        end
        if (accept) begin
            cache_rd_reg <= cache_mem[s_address[OFF_BITS +: SET_BITS]];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            back_mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            mem_rd_reg <= back_mem[s_address[ADDR_BITS-1:OFF_BITS]];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_byte = m_read_byte_reg;
    assign m_line_data = m_line_data_reg;
    assign m_hit       = m_hit_reg;
    assign m_was_dirty = m_was_dirty_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transfer taken while an item is in flight");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg == ST_SELECT) |-> !hit_reg)
        else $error("backing memory written back on a hit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_SELECT))
        else $error("result raised outside the select step");

endmodule

`default_nettype wire
